// ----- src/ccf_pkg.sv -----
// Shared widths, codes and record types for the circle center pipeline.
// Used by every module of the block; the channel interfaces do not import it.
`default_nettype none

package ccf_pkg;

    localparam int COORD_W  = 32;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int SPLIT_W  = 33;
    localparam int SUM_HI_W = SUM_W - SPLIT_W;
    localparam int PLO_W    = DIFF_W + SPLIT_W;
    localparam int PHI_W    = DIFF_W + SUM_HI_W;
    localparam int PMAG_W   = 97;
    localparam int NUM_W    = PMAG_W + 2;
    localparam int NMAG_W   = NUM_W - 1;
    localparam int DEN_W    = 2 * DIFF_W + 2;
    localparam int DMAG_W   = DEN_W - 1;
    localparam int QB       = 34;
    localparam int DIV_W    = DMAG_W + QB;
    localparam int QR_W     = QB + 1;
    localparam int OFF_W    = QR_W + 1;
    localparam int CEN_W    = OFF_W + 1;
    localparam int SQR_W    = 2 * QB;
    localparam int SSUM_W   = SQR_W + 1;
    localparam int RAD_IN_W = 64;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = RAD_IN_W + 2;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic [SSUM_W-1:0]  RAD_SQ_MAX = SSUM_W'(64'hFFFF_FFFF_0000_0000);

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_DEGENERATE = 2'd1;
    localparam logic [1:0] STATUS_SATURATED  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
    } point_set_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic signed [COORD_W-1:0] z;
    } side_t;

    typedef struct packed {
        logic [NMAG_W-1:0] nmag_x;
        logic [NMAG_W-1:0] nmag_y;
        logic              neg_x;
        logic              neg_y;
        logic [DMAG_W-1:0] dmag;
        logic              deg;
        side_t             side;
    } div_in_t;

    typedef struct packed {
        logic [QB-1:0]     q_x;
        logic [QB-1:0]     q_y;
        logic [DMAG_W-1:0] rem_x;
        logic [DMAG_W-1:0] rem_y;
        logic [DMAG_W-1:0] dmag;
        logic              neg_x;
        logic              neg_y;
        logic              big_x;
        logic              big_y;
        logic              deg;
        side_t             side;
    } div_out_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] center_z;
        logic               sat;
        logic               rad_ovf;
        logic               deg;
    } post_t;

    typedef struct packed {
        logic [RAD_IN_W-1:0] s;
        post_t               post;
    } sqrt_in_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
        post_t             post;
    } sqrt_out_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] center_z;
        logic [COORD_W-1:0] radius;
        logic [1:0]         status;
    } result_t;

endpackage

`default_nettype wire

// ----- src/ccf_if.sv -----
// Valid/ready channel interfaces for the point request and the circle result.
// Stand-alone; the widths match the constants of ccf_pkg.
`default_nettype none

interface ccf_points_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                    third_x, third_y, input ready);
    modport sink (input valid, first_x, first_y, first_z, second_x, second_y,
                  third_x, third_y, output ready);
endinterface

interface ccf_circle_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [31:0]        radius;
    logic [1:0]         status;

    modport source (output valid, center_x, center_y, center_z, radius, status,
                    input ready);
    modport sink (input valid, center_x, center_y, center_z, radius, status,
                  output ready);
endinterface

`default_nettype wire

// ----- src/ccf_front.sv -----
// Front end: edge vectors, squared lengths, determinant and numerators.
// Seven register stages; depends on ccf_pkg.
`default_nettype none

module ccf_front
    import ccf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire point_set_t in_data,
    output logic            out_valid,
    output div_in_t         out_data
);

    logic [6:0] vld_reg;

    // Stage 1: edge vectors from the first point.
    logic signed [DIFF_W-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    side_t s1_reg;

    // Stage 2: products of the edge components.
    logic signed [2*DIFF_W-1:0] p_uxux, p_uyuy, p_vxvx, p_vyvy, p_uxvy, p_uyvx;
    logic [SQ_W-1:0] uxux_reg, uyuy_reg, vxvx_reg, vyvy_reg;
    logic signed [2*DIFF_W-1:0] uxvy_reg, uyvx_reg;
    logic signed [DIFF_W-1:0] ux2_reg, uy2_reg, vx2_reg, vy2_reg;
    side_t s2_reg;

    // Stage 3: squared lengths, determinant and magnitudes.
    logic signed [DEN_W-2:0] cross_d;
    logic [SUM_W-1:0] su_reg, sv_reg;
    logic signed [DEN_W-1:0] den3_reg;
    logic [DIFF_W-1:0] mux_reg, muy_reg, mvx_reg, mvy_reg;
    logic nux_reg, nuy_reg, nvx_reg, nvy_reg;
    side_t s3_reg;

    // Stage 4: partial products of the numerators.
    logic [PLO_W-1:0] a_lo_reg, b_lo_reg, c_lo_reg, d_lo_reg;
    logic [PHI_W-1:0] a_hi_reg, b_hi_reg, c_hi_reg, d_hi_reg;
    logic sa4_reg, sb4_reg, sc4_reg, sd4_reg;
    logic signed [DEN_W-1:0] den4_reg;
    side_t s4_reg;

    // Stage 5: product magnitudes.
    logic [PMAG_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic sa5_reg, sb5_reg, sc5_reg, sd5_reg;
    logic signed [DEN_W-1:0] den5_reg;
    side_t s5_reg;

    // Stage 6: signed numerators.
    logic signed [NUM_W-1:0] ta, tb, tc, td;
    logic signed [NUM_W-1:0] nx_reg, ny_reg;
    logic signed [DEN_W-1:0] den6_reg;
    side_t s6_reg;

    // Stage 7: magnitudes for the divider.
    logic signed [NUM_W-1:0] anx, any_n;
    logic signed [DEN_W-1:0] aden;
    div_in_t out_reg;

    assign p_uxux = ux_reg * ux_reg;
    assign p_uyuy = uy_reg * uy_reg;
    assign p_vxvx = vx_reg * vx_reg;
    assign p_vyvy = vy_reg * vy_reg;
    assign p_uxvy = ux_reg * vy_reg;
    assign p_uyvx = uy_reg * vx_reg;

    assign cross_d = (DEN_W-1)'(uxvy_reg) - (DEN_W-1)'(uyvx_reg);

    assign ta = sa5_reg ? -$signed({2'b00, pa_reg}) : $signed({2'b00, pa_reg});
    assign tb = sb5_reg ? -$signed({2'b00, pb_reg}) : $signed({2'b00, pb_reg});
    assign tc = sc5_reg ? -$signed({2'b00, pc_reg}) : $signed({2'b00, pc_reg});
    assign td = sd5_reg ? -$signed({2'b00, pd_reg}) : $signed({2'b00, pd_reg});

    assign anx   = nx_reg[NUM_W-1] ? -nx_reg : nx_reg;
    assign any_n = ny_reg[NUM_W-1] ? -ny_reg : ny_reg;
    assign aden  = den6_reg[DEN_W-1] ? -den6_reg : den6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= DIFF_W'(in_data.second_x) - DIFF_W'(in_data.first_x);
            uy_reg <= DIFF_W'(in_data.second_y) - DIFF_W'(in_data.first_y);
            vx_reg <= DIFF_W'(in_data.third_x) - DIFF_W'(in_data.first_x);
            vy_reg <= DIFF_W'(in_data.third_y) - DIFF_W'(in_data.first_y);
            s1_reg.base_x <= in_data.first_x;
            s1_reg.base_y <= in_data.first_y;
            s1_reg.z      <= in_data.first_z;

            uxux_reg <= p_uxux[SQ_W-1:0];
            uyuy_reg <= p_uyuy[SQ_W-1:0];
            vxvx_reg <= p_vxvx[SQ_W-1:0];
            vyvy_reg <= p_vyvy[SQ_W-1:0];
            uxvy_reg <= p_uxvy;
            uyvx_reg <= p_uyvx;
            ux2_reg  <= ux_reg;
            uy2_reg  <= uy_reg;
            vx2_reg  <= vx_reg;
            vy2_reg  <= vy_reg;
            s2_reg   <= s1_reg;

            su_reg   <= SUM_W'(uxux_reg) + SUM_W'(uyuy_reg);
            sv_reg   <= SUM_W'(vxvx_reg) + SUM_W'(vyvy_reg);
            den3_reg <= {cross_d, 1'b0};
            mux_reg  <= ux2_reg[DIFF_W-1] ? $unsigned(-ux2_reg) : $unsigned(ux2_reg);
            muy_reg  <= uy2_reg[DIFF_W-1] ? $unsigned(-uy2_reg) : $unsigned(uy2_reg);
            mvx_reg  <= vx2_reg[DIFF_W-1] ? $unsigned(-vx2_reg) : $unsigned(vx2_reg);
            mvy_reg  <= vy2_reg[DIFF_W-1] ? $unsigned(-vy2_reg) : $unsigned(vy2_reg);
            nux_reg  <= ux2_reg[DIFF_W-1];
            nuy_reg  <= uy2_reg[DIFF_W-1];
            nvx_reg  <= vx2_reg[DIFF_W-1];
            nvy_reg  <= vy2_reg[DIFF_W-1];
            s3_reg   <= s2_reg;

            // nx = vy*su - uy*sv, ny = ux*sv - vx*su
            a_lo_reg <= mvy_reg * su_reg[SPLIT_W-1:0];
            a_hi_reg <= mvy_reg * su_reg[SUM_W-1:SPLIT_W];
            b_lo_reg <= muy_reg * sv_reg[SPLIT_W-1:0];
            b_hi_reg <= muy_reg * sv_reg[SUM_W-1:SPLIT_W];
            c_lo_reg <= mux_reg * sv_reg[SPLIT_W-1:0];
            c_hi_reg <= mux_reg * sv_reg[SUM_W-1:SPLIT_W];
            d_lo_reg <= mvx_reg * su_reg[SPLIT_W-1:0];
            d_hi_reg <= mvx_reg * su_reg[SUM_W-1:SPLIT_W];
            sa4_reg  <= nvy_reg;
            sb4_reg  <= nuy_reg;
            sc4_reg  <= nux_reg;
            sd4_reg  <= nvx_reg;
            den4_reg <= den3_reg;
            s4_reg   <= s3_reg;

            pa_reg   <= PMAG_W'(a_lo_reg) + (PMAG_W'(a_hi_reg) << SPLIT_W);
            pb_reg   <= PMAG_W'(b_lo_reg) + (PMAG_W'(b_hi_reg) << SPLIT_W);
            pc_reg   <= PMAG_W'(c_lo_reg) + (PMAG_W'(c_hi_reg) << SPLIT_W);
            pd_reg   <= PMAG_W'(d_lo_reg) + (PMAG_W'(d_hi_reg) << SPLIT_W);
            sa5_reg  <= sa4_reg;
            sb5_reg  <= sb4_reg;
            sc5_reg  <= sc4_reg;
            sd5_reg  <= sd4_reg;
            den5_reg <= den4_reg;
            s5_reg   <= s4_reg;

            nx_reg   <= ta - tb;
            ny_reg   <= tc - td;
            den6_reg <= den5_reg;
            s6_reg   <= s5_reg;

            out_reg.nmag_x <= anx[NMAG_W-1:0];
            out_reg.nmag_y <= any_n[NMAG_W-1:0];
            out_reg.neg_x  <= nx_reg[NUM_W-1];
            out_reg.neg_y  <= ny_reg[NUM_W-1];
            out_reg.dmag   <= aden[DMAG_W-1:0];
            out_reg.deg    <= (den6_reg == '0);
            out_reg.side   <= s6_reg;
        end
    end

    assign out_valid = vld_reg[6];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ----- src/ccf_div.sv -----
// Pipelined restoring divider for both center offsets, one quotient bit a stage.
// Carries the range check and the remainder for rounding; depends on ccf_pkg.
`default_nettype none

module ccf_div
    import ccf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire div_in_t in_data,
    output logic         out_valid,
    output div_out_t     out_data
);

    typedef struct packed {
        logic [DIV_W-1:0]  rem_x;
        logic [DIV_W-1:0]  rem_y;
        logic [QB-1:0]     q_x;
        logic [QB-1:0]     q_y;
        logic [DMAG_W-1:0] dmag;
        logic              neg_x;
        logic              neg_y;
        logic              big_x;
        logic              big_y;
        logic              deg;
        side_t             side;
    } dstage_t;

    logic [QB:0] vld_reg;
    dstage_t     st_reg [QB+1];
    logic [DIV_W-1:0] dlim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QB-1:0], in_valid};
        end
    end

    // A quotient of 2^QB or more cannot land in the output range.
    assign dlim = DIV_W'(in_data.dmag) << QB;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].rem_x <= DIV_W'(in_data.nmag_x);
            st_reg[0].rem_y <= DIV_W'(in_data.nmag_y);
            st_reg[0].q_x   <= '0;
            st_reg[0].q_y   <= '0;
            st_reg[0].dmag  <= in_data.dmag;
            st_reg[0].neg_x <= in_data.neg_x;
            st_reg[0].neg_y <= in_data.neg_y;
            st_reg[0].big_x <= DIV_W'(in_data.nmag_x) >= dlim;
            st_reg[0].big_y <= DIV_W'(in_data.nmag_y) >= dlim;
            st_reg[0].deg   <= in_data.deg;
            st_reg[0].side  <= in_data.side;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        localparam int SH = QB - 1 - k;
        logic [DIV_W-1:0] dsh;
        logic             ge_x, ge_y;

        assign dsh  = DIV_W'(st_reg[k].dmag) << SH;
        assign ge_x = st_reg[k].rem_x >= dsh;
        assign ge_y = st_reg[k].rem_y >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k+1].dmag  <= st_reg[k].dmag;
                st_reg[k+1].neg_x <= st_reg[k].neg_x;
                st_reg[k+1].neg_y <= st_reg[k].neg_y;
                st_reg[k+1].big_x <= st_reg[k].big_x;
                st_reg[k+1].big_y <= st_reg[k].big_y;
                st_reg[k+1].deg   <= st_reg[k].deg;
                st_reg[k+1].side  <= st_reg[k].side;
                st_reg[k+1].rem_x <= ge_x ? st_reg[k].rem_x - dsh : st_reg[k].rem_x;
                st_reg[k+1].rem_y <= ge_y ? st_reg[k].rem_y - dsh : st_reg[k].rem_y;
                st_reg[k+1].q_x   <= {st_reg[k].q_x[QB-2:0], ge_x};
                st_reg[k+1].q_y   <= {st_reg[k].q_y[QB-2:0], ge_y};
            end
        end
    end

    assign out_valid      = vld_reg[QB];
    assign out_data.q_x   = st_reg[QB].q_x;
    assign out_data.q_y   = st_reg[QB].q_y;
    assign out_data.rem_x = st_reg[QB].rem_x[DMAG_W-1:0];
    assign out_data.rem_y = st_reg[QB].rem_y[DMAG_W-1:0];
    assign out_data.dmag  = st_reg[QB].dmag;
    assign out_data.neg_x = st_reg[QB].neg_x;
    assign out_data.neg_y = st_reg[QB].neg_y;
    assign out_data.big_x = st_reg[QB].big_x;
    assign out_data.big_y = st_reg[QB].big_y;
    assign out_data.deg   = st_reg[QB].deg;
    assign out_data.side  = st_reg[QB].side;

endmodule

`default_nettype wire

// ----- src/ccf_sqrt.sv -----
// Pipelined integer square root with remainder, one result bit a stage.
// Carries the finished center fields alongside; depends on ccf_pkg.
`default_nettype none

module ccf_sqrt
    import ccf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire sqrt_in_t in_data,
    output logic          out_valid,
    output sqrt_out_t     out_data
);

    logic [ROOT_W:0] vld_reg;
    sqrt_out_t       st_reg [ROOT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ROOT_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].root <= '0;
            st_reg[0].rem  <= REM_W'(in_data.s);
            st_reg[0].post <= in_data.post;
        end
    end

    // Setting bit b of the root adds root*2^(b+1) + 4^b to its square.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        localparam int B = ROOT_W - 1 - k;
        logic [REM_W-1:0] term;
        logic             ge;

        assign term = (REM_W'(st_reg[k].root) << (B + 1)) + (REM_W'(1) << (2 * B));
        assign ge   = st_reg[k].rem >= term;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k+1].post <= st_reg[k].post;
                st_reg[k+1].rem  <= ge ? st_reg[k].rem - term : st_reg[k].rem;
                st_reg[k+1].root <= ge ? (st_reg[k].root | (ROOT_W'(1) << B))
                                       : st_reg[k].root;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign out_data  = st_reg[ROOT_W];

endmodule

`default_nettype wire

// ----- src/ccf_skid.sv -----
// Output register with a one-entry skid buffer; its free slot gates the pipeline.
// Drives the circle result channel; depends on ccf_pkg and ccf_if.
`default_nettype none

module ccf_skid
    import ccf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire result_t in_data,
    output logic         en,
    ccf_circle_if.source circle
);

    logic    out_vld_reg, out_vld_next;
    logic    skid_vld_reg, skid_vld_next;
    result_t out_reg, skid_reg;
    logic    take, load, incoming;

    assign en       = !skid_vld_reg;
    assign incoming = in_valid && en;
    assign take     = out_vld_reg && circle.ready;
    assign load     = !out_vld_reg || take;

    always_comb
    begin
        if (load)
        begin
            out_vld_next  = skid_vld_reg || incoming;
            skid_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next  = 1'b1;
            skid_vld_next = skid_vld_reg || incoming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= skid_vld_reg ? skid_reg : in_data;
        end
        else if (incoming)
        begin
            skid_reg <= in_data;
        end
    end

    assign circle.valid    = out_vld_reg;
    assign circle.center_x = out_reg.center_x;
    assign circle.center_y = out_reg.center_y;
    assign circle.center_z = out_reg.center_z;
    assign circle.radius   = out_reg.radius;
    assign circle.status   = out_reg.status;

endmodule

`default_nettype wire

// ----- src/circle_center_from_three_points.sv -----
// Circle center from three probed points, Q16.16 fixed point.
// A request on the points channel carries three XY points and the first Z;
// one result on the circle channel gives the circumcenter, the Z copied
// through, the radius measured to the first point, and a status code.
// Collinear or coincident points give zero fields with status degenerate;
// a center or radius beyond range saturates with status saturated.
// The datapath is a fixed pipeline: 7 stages of products and numerators,
// 35 divider stages (a load stage, then one quotient bit each), 3 rounding
// and center stages, 33 square root stages (a load stage, then one root bit
// each) and the output register. A new request is accepted every cycle
// while points.ready is high, with no dependence between requests.
// Reset clears every valid bit; no request is in flight afterward.
// When the receiver stalls, the output register holds its result and one
// more result parks in a skid register; only then does the pipeline freeze
// and points.ready fall, so a stall loses and repeats nothing.
// Depends on ccf_pkg, ccf_if, ccf_front, ccf_div, ccf_sqrt and ccf_skid.
`default_nettype none

module circle_center_from_three_points
    import ccf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    ccf_points_if.sink   points,
    ccf_circle_if.source circle
);

    logic       en;
    point_set_t pts;
    logic       front_valid, div_valid, sqrt_valid;
    div_in_t    front_data;
    div_out_t   div_data;
    sqrt_in_t   sqrt_in;
    sqrt_out_t  sqrt_data;
    result_t    result;

    logic [2:0] vld_reg;

    // Stage P1: rounded quotient magnitudes.
    logic [QR_W-1:0] qr_x, qr_y;
    logic [QR_W-1:0] qr_x_reg, qr_y_reg;
    logic small1_x_reg, small1_y_reg, neg1_x_reg, neg1_y_reg, deg1_reg;
    side_t s1_reg;

    // Stage P2: signed offsets and their squares.
    logic signed [OFF_W-1:0] off_x, off_y;
    logic [SQR_W-1:0] sq_x, sq_y;
    logic signed [OFF_W-1:0] off_x_reg, off_y_reg;
    logic [SQR_W-1:0] sq_x_reg, sq_y_reg;
    logic small2_x_reg, small2_y_reg, neg2_x_reg, neg2_y_reg, deg2_reg;
    side_t s2_reg;

    // Stage P3: clamped center and squared radius.
    logic signed [CEN_W-1:0] cen_x, cen_y;
    logic [COORD_W:0] cl_x, cl_y;
    logic [COORD_W-1:0] cx_reg, cy_reg, z3_reg;
    logic [SSUM_W-1:0] s3_sum_reg;
    logic small3_x_reg, small3_y_reg, sat3_reg, deg3_reg;

    // Output formatting.
    logic              round_up;
    logic [ROOT_W-1:0] rad;

    function automatic logic [COORD_W:0] clamp_axis(
        input logic signed [CEN_W-1:0] cen,
        input logic                    small_ok,
        input logic                    neg
    );
        logic [CEN_W-COORD_W:0] head;
        begin
            head = cen[CEN_W-1:COORD_W-1];
            if (!small_ok)
            begin
                return {1'b1, neg ? COORD_MIN : COORD_MAX};
            end
            else if (head != '0 && head != '1)
            begin
                return {1'b1, cen[CEN_W-1] ? COORD_MIN : COORD_MAX};
            end
            else
            begin
                return {1'b0, cen[COORD_W-1:0]};
            end
        end
    endfunction

    assign pts.first_x  = points.first_x;
    assign pts.first_y  = points.first_y;
    assign pts.first_z  = points.first_z;
    assign pts.second_x = points.second_x;
    assign pts.second_y = points.second_y;
    assign pts.third_x  = points.third_x;
    assign pts.third_y  = points.third_y;
    assign points.ready = en;

    ccf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (points.valid),
        .in_data   (pts),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    ccf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    // Round to nearest, ties away from zero: bump when twice the remainder
    // reaches the divisor.
    assign qr_x = QR_W'(div_data.q_x)
                + QR_W'({div_data.rem_x, 1'b0} >= {1'b0, div_data.dmag});
    assign qr_y = QR_W'(div_data.q_y)
                + QR_W'({div_data.rem_y, 1'b0} >= {1'b0, div_data.dmag});

    assign off_x = neg1_x_reg ? -$signed(OFF_W'(qr_x_reg)) : $signed(OFF_W'(qr_x_reg));
    assign off_y = neg1_y_reg ? -$signed(OFF_W'(qr_y_reg)) : $signed(OFF_W'(qr_y_reg));
    assign sq_x  = qr_x_reg[QB-1:0] * qr_x_reg[QB-1:0];
    assign sq_y  = qr_y_reg[QB-1:0] * qr_y_reg[QB-1:0];

    assign cen_x = CEN_W'(s2_reg.base_x) + CEN_W'(off_x_reg);
    assign cen_y = CEN_W'(s2_reg.base_y) + CEN_W'(off_y_reg);
    assign cl_x  = clamp_axis(cen_x, small2_x_reg, neg2_x_reg);
    assign cl_y  = clamp_axis(cen_y, small2_y_reg, neg2_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], div_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qr_x_reg     <= qr_x;
            qr_y_reg     <= qr_y;
            small1_x_reg <= !div_data.big_x && !qr_x[QB];
            small1_y_reg <= !div_data.big_y && !qr_y[QB];
            neg1_x_reg   <= div_data.neg_x;
            neg1_y_reg   <= div_data.neg_y;
            deg1_reg     <= div_data.deg;
            s1_reg       <= div_data.side;

            off_x_reg    <= off_x;
            off_y_reg    <= off_y;
            sq_x_reg     <= sq_x;
            sq_y_reg     <= sq_y;
            small2_x_reg <= small1_x_reg;
            small2_y_reg <= small1_y_reg;
            neg2_x_reg   <= neg1_x_reg;
            neg2_y_reg   <= neg1_y_reg;
            deg2_reg     <= deg1_reg;
            s2_reg       <= s1_reg;

            cx_reg       <= cl_x[COORD_W-1:0];
            cy_reg       <= cl_y[COORD_W-1:0];
            sat3_reg     <= cl_x[COORD_W] || cl_y[COORD_W];
            z3_reg       <= s2_reg.z;
            s3_sum_reg   <= SSUM_W'(sq_x_reg) + SSUM_W'(sq_y_reg);
            small3_x_reg <= small2_x_reg;
            small3_y_reg <= small2_y_reg;
            deg3_reg     <= deg2_reg;
        end
    end

    assign sqrt_in.s             = s3_sum_reg[RAD_IN_W-1:0];
    assign sqrt_in.post.center_x = cx_reg;
    assign sqrt_in.post.center_y = cy_reg;
    assign sqrt_in.post.center_z = z3_reg;
    assign sqrt_in.post.sat      = sat3_reg;
    assign sqrt_in.post.rad_ovf  = !small3_x_reg || !small3_y_reg
                                 || (s3_sum_reg > RAD_SQ_MAX);
    assign sqrt_in.post.deg      = deg3_reg;

    ccf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[2]),
        .in_data   (sqrt_in),
        .out_valid (sqrt_valid),
        .out_data  (sqrt_data)
    );

    // Round the root up when the remainder exceeds the root.
    assign round_up = sqrt_data.rem > REM_W'(sqrt_data.root);
    assign rad      = sqrt_data.root + ROOT_W'(round_up);

    always_comb
    begin
        if (sqrt_data.post.deg)
        begin
            result.center_x = '0;
            result.center_y = '0;
            result.center_z = '0;
            result.radius   = '0;
            result.status   = STATUS_DEGENERATE;
        end
        else
        begin
            result.center_x = sqrt_data.post.center_x;
            result.center_y = sqrt_data.post.center_y;
            result.center_z = sqrt_data.post.center_z;
            result.radius   = sqrt_data.post.rad_ovf ? '1 : rad;
            result.status   = (sqrt_data.post.sat || sqrt_data.post.rad_ovf)
                            ? STATUS_SATURATED : STATUS_OK;
        end
    end

    ccf_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sqrt_valid),
        .in_data  (result),
        .en       (en),
        .circle   (circle)
    );

endmodule

`default_nettype wire
